/* rtl/smra_pkg.sv */
// Shared types and codes for the sparse row accumulator.
package smra_pkg;

  localparam int ColW   = 6;
  localparam int RowW   = 9;
  localparam int SlotW  = 13;
  localparam int ValW   = 8;
  localparam int SumW   = 32;
  localparam int NcolW  = 7;
  localparam int KindW  = 3;

  localparam logic [1:0] OP_PTR_WR = 2'd0;
  localparam logic [1:0] OP_ENT_WR = 2'd1;
  localparam logic [1:0] OP_A_NZ   = 2'd2;
  localparam logic [1:0] OP_ROW_END = 2'd3;

  localparam logic [KindW-1:0] K_NOP    = 3'd0;
  localparam logic [KindW-1:0] K_PTR_WR = 3'd1;
  localparam logic [KindW-1:0] K_ENT_WR = 3'd2;
  localparam logic [KindW-1:0] K_WALK   = 3'd3;
  localparam logic [KindW-1:0] K_FLUSH  = 3'd4;

  typedef struct packed {
    logic [KindW-1:0]    kind;
    logic [RowW-1:0]     row_index;
    logic [SlotW-1:0]    slot;
    logic [ColW-1:0]     column;
    logic signed [ValW-1:0] value;
  } smra_cmd_t;

endpackage

/* rtl/smra_if.sv */
// Handshake channels for input words and result words.
interface smra_in_if;
  logic                   valid;
  logic                   ready;
  logic [1:0]             opcode;
  logic [8:0]             row_index;
  logic [12:0]            slot;
  logic [5:0]             column;
  logic signed [7:0]      value;
  modport source(output valid, opcode, row_index, slot, column, value, input ready);
  modport sink(input valid, opcode, row_index, slot, column, value, output ready);
endinterface

interface smra_out_if;
  logic                   valid;
  logic                   ready;
  logic [5:0]             out_column;
  logic signed [31:0]     out_value;
  logic                   has_entry;
  logic                   last;
  modport source(output valid, out_column, out_value, has_entry, last, input ready);
  modport sink(input valid, out_column, out_value, has_entry, last, output ready);
endinterface

/* rtl/smra_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module smra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/smra_front.sv */
// Front end: accept input words, classify them, and queue commands.
module smra_front import smra_pkg::*; #(
  parameter int MAX_B_ROWS = 256,
  parameter int B_CAPACITY = 4096
) (
  input  logic      clk,
  input  logic      rst,
  smra_in_if.sink   req,
  output smra_cmd_t cmd,
  output logic      cmd_valid,
  input  logic      cmd_pop
);

  localparam int Depth = 4;
  localparam int PtrW  = 2;

  smra_cmd_t        queue [Depth];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [PtrW:0]    count;
  smra_cmd_t        incoming;
  logic             push;
  logic             pop;

  assign req.ready = (count < (PtrW+1)'(Depth));
  assign push      = req.valid && req.ready;
  assign pop       = cmd_pop && cmd_valid;
  assign cmd_valid = (count != '0);
  assign cmd       = queue[rd_ptr];

  // Turn out-of-range writes and walks into no-ops here; the back end pops and ignores them.
  always_comb begin
    incoming.row_index = req.row_index;
    incoming.slot      = req.slot;
    incoming.column    = req.column;
    incoming.value     = req.value;
    incoming.kind      = K_NOP;
    case (req.opcode)
      OP_PTR_WR: begin
        if (32'(req.row_index) <= MAX_B_ROWS) incoming.kind = K_PTR_WR;
      end
      OP_ENT_WR: begin
        if (32'(req.slot) < B_CAPACITY) incoming.kind = K_ENT_WR;
      end
      OP_A_NZ: begin
        if (32'(req.row_index) < MAX_B_ROWS) incoming.kind = K_WALK;
      end
      OP_ROW_END: begin
        incoming.kind = K_FLUSH;
      end
      default: incoming.kind = K_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= incoming;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/smra_back.sv */
// Back end: B store writes, row walks into the accumulator, and row flush.
module smra_back import smra_pkg::*; #(
  parameter int MAX_COLS   = 64,
  parameter int MAX_B_ROWS = 256,
  parameter int B_CAPACITY = 4096
) (
  input  logic                   clk,
  input  logic                   rst,
  input  smra_cmd_t              cmd,
  input  logic                   cmd_valid,
  output logic                   cmd_pop,
  input  logic [NcolW-1:0]       ncols,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [ColW-1:0]        out_column,
  output logic signed [SumW-1:0] out_value,
  output logic                   has_entry,
  output logic                   last
);

  localparam int RW = $clog2(MAX_B_ROWS + 1);
  localparam int EW = (B_CAPACITY > 1) ? $clog2(B_CAPACITY) : 1;
  localparam int SW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_PTR1  = 4'd1;
  localparam logic [3:0] ST_PTR2  = 4'd2;
  localparam logic [3:0] ST_ERD   = 4'd3;
  localparam logic [3:0] ST_EWAIT = 4'd4;
  localparam logic [3:0] ST_ACC   = 4'd5;
  localparam logic [3:0] ST_SRD   = 4'd6;
  localparam logic [3:0] ST_SCHK  = 4'd7;
  localparam logic [3:0] ST_SFIN  = 4'd8;

  logic [3:0]              state;
  logic [RW-1:0]           row;
  logic signed [ValW-1:0]  a_val;
  logic [SlotW-1:0]        idx;
  logic [SlotW-1:0]        idx_end;
  logic [ColW-1:0]         b_col;
  logic signed [ValW-1:0]  b_val;
  logic [NcolW-1:0]        scan;
  logic                    pend_v;
  logic [ColW-1:0]         pend_col;
  logic [SumW-1:0]         pend_val;
  logic [MAX_COLS-1:0]     sum_ok;

  logic                    rs_we, rs_re;
  logic [RW-1:0]           rs_waddr, rs_raddr;
  logic [SlotW-1:0]        rs_rdata;
  logic                    en_we, en_re;
  logic [ColW+ValW-1:0]    en_rdata;
  logic                    sm_we, sm_re;
  logic [SW-1:0]           sm_waddr, sm_raddr;
  logic [SumW-1:0]         sm_wdata, sm_rdata;

  logic                    out_free;
  logic                    out_load;
  logic [SumW-1:0]         sum_cur;
  logic [SlotW-1:0]        end_clip;
  logic signed [2*ValW-1:0] prod;

  assign out_free = !out_valid || out_ready;
  assign cmd_pop  = (state == ST_IDLE) && cmd_valid;
  assign end_clip = (32'(rs_rdata) > B_CAPACITY) ? SlotW'(B_CAPACITY) : rs_rdata;
  assign prod     = a_val * b_val;
  assign out_load = ((state == ST_SCHK) && (sum_cur != '0) && pend_v && out_free)
                 || ((state == ST_SFIN) && out_free);

  always_comb begin
    sum_cur = '0;
    if (state == ST_ACC) begin
      if (sum_ok[SW'(b_col)]) sum_cur = sm_rdata;
    end else if (sum_ok[SW'(scan)]) begin
      sum_cur = sm_rdata;
    end
  end

  assign rs_we    = cmd_pop && (cmd.kind == K_PTR_WR);
  assign rs_waddr = RW'(cmd.row_index);
  assign rs_re    = (cmd_pop && (cmd.kind == K_WALK)) || (state == ST_PTR1);
  assign rs_raddr = (state == ST_PTR1) ? row + 1'b1 : RW'(cmd.row_index);

  assign en_we = cmd_pop && (cmd.kind == K_ENT_WR);
  assign en_re = (state == ST_ERD) && (idx < idx_end);

  assign sm_we    = (state == ST_ACC);
  assign sm_waddr = SW'(b_col);
  assign sm_wdata = sum_cur + SumW'(prod);
  assign sm_re    = ((state == ST_EWAIT) && (7'(en_rdata[ColW+ValW-1:ValW]) < ncols))
                 || ((state == ST_SRD) && (scan < ncols));
  assign sm_raddr = (state == ST_EWAIT) ? SW'(en_rdata[ColW+ValW-1:ValW]) : SW'(scan);

  smra_ram #(.WIDTH(SlotW), .DEPTH(MAX_B_ROWS + 1), .AW(RW)) u_row_start (
    .clk(clk), .we(rs_we), .waddr(rs_waddr), .wdata(cmd.slot),
    .re(rs_re), .raddr(rs_raddr), .rdata(rs_rdata)
  );

  smra_ram #(.WIDTH(ColW + ValW), .DEPTH(B_CAPACITY), .AW(EW)) u_entries (
    .clk(clk), .we(en_we), .waddr(EW'(cmd.slot)), .wdata({cmd.column, cmd.value}),
    .re(en_re), .raddr(EW'(idx)), .rdata(en_rdata)
  );

  smra_ram #(.WIDTH(SumW), .DEPTH(MAX_COLS), .AW(SW)) u_row_sum (
    .clk(clk), .we(sm_we), .waddr(sm_waddr), .wdata(sm_wdata),
    .re(sm_re), .raddr(sm_raddr), .rdata(sm_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      sum_ok    <= '0;
      out_valid <= 1'b0;
      pend_v    <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            case (cmd.kind)
              K_WALK: begin
                row   <= RW'(cmd.row_index);
                a_val <= cmd.value;
                state <= ST_PTR1;
              end
              K_FLUSH: begin
                scan   <= '0;
                pend_v <= 1'b0;
                state  <= ST_SRD;
              end
              default: state <= ST_IDLE;
            endcase
          end
        end
        ST_PTR1: begin
          idx   <= rs_rdata;
          state <= ST_PTR2;
        end
        ST_PTR2: begin
          idx_end <= end_clip;
          state   <= ST_ERD;
        end
        ST_ERD: begin
          state <= (idx < idx_end) ? ST_EWAIT : ST_IDLE;
        end
        ST_EWAIT: begin
          b_col <= en_rdata[ColW+ValW-1:ValW];
          b_val <= en_rdata[ValW-1:0];
          if (sm_re) begin
            state <= ST_ACC;
          end else begin
            idx   <= idx + 1'b1;
            state <= ST_ERD;
          end
        end
        ST_ACC: begin
          sum_ok[SW'(b_col)] <= 1'b1;
          idx   <= idx + 1'b1;
          state <= ST_ERD;
        end
        ST_SRD: begin
          state <= (scan < ncols) ? ST_SCHK : ST_SFIN;
        end
        ST_SCHK: begin
          // Hold one nonzero back so the final one can carry last.
          if (sum_cur == '0) begin
            scan  <= scan + 1'b1;
            state <= ST_SRD;
          end else if (!pend_v || out_free) begin
            if (pend_v) begin
              out_column <= pend_col;
              out_value  <= pend_val;
              has_entry  <= 1'b1;
              last       <= 1'b0;
            end
            pend_v   <= 1'b1;
            pend_col <= ColW'(scan);
            pend_val <= sum_cur;
            scan     <= scan + 1'b1;
            state    <= ST_SRD;
          end
        end
        ST_SFIN: begin
          if (out_free) begin
            out_column <= pend_v ? pend_col : '0;
            out_value  <= pend_v ? pend_val : '0;
            has_entry  <= pend_v;
            last       <= 1'b1;
            sum_ok     <= '0;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

/* rtl/sparse_matmul_row_accumulator.sv */
// Top level of the row-wise sparse matrix multiply accumulator.
// Usage:
//   req carries command words (opcode, row_index, slot, column, value);
//   rsp carries result words (out_column, out_value, has_entry, last).
//   cfg_write/cfg_data set the number of columns in use while idle.
// Opcode 0/1 load the B row pointers and entries; opcode 2 walks B row k
// and adds a*b into the accumulator; opcode 3 emits nonzero sums in column
// order, last flagged, or one empty word, then clears the accumulator.
// Structure: words pass a 4-deep command queue, then one back-end sequencer.
// A store write is done as the word is popped; an A nonzero reads the row
// pointers, then per B entry of the row an entry read, sum read and sum
// write (no sum access for an entry whose column is out of use); a row end
// reads each column in use in turn through the single read port of the sum RAM.
// The queue accepts while the back end works until it holds 4 words.
// Reset clears the queue, the sequencer, the output valid bit and the
// accumulator valid bits at once; no clearing pass is needed.
// A stalled receiver holds the output word; the scan waits on it.
module sparse_matmul_row_accumulator import smra_pkg::*; #(
  parameter int MAX_COLS   = 64,
  parameter int MAX_B_ROWS = 256,
  parameter int B_CAPACITY = 4096
) (
  input  logic             clk,
  input  logic             rst,
  smra_in_if.sink          req,
  smra_out_if.source       rsp,
  input  logic             cfg_write,
  input  logic [NcolW-1:0] cfg_data
);

  logic [NcolW-1:0] cols_in_use;
  logic [NcolW-1:0] ncols;
  smra_cmd_t        cmd;
  logic             cmd_valid;
  logic             cmd_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cols_in_use <= NcolW'(64);
    end else if (cfg_write) begin
      cols_in_use <= cfg_data;
    end
  end

  assign ncols = (32'(cols_in_use) > MAX_COLS) ? NcolW'(MAX_COLS) : cols_in_use;

  smra_front #(.MAX_B_ROWS(MAX_B_ROWS), .B_CAPACITY(B_CAPACITY)) u_front (
    .clk(clk), .rst(rst), .req(req),
    .cmd(cmd), .cmd_valid(cmd_valid), .cmd_pop(cmd_pop)
  );

  smra_back #(.MAX_COLS(MAX_COLS), .MAX_B_ROWS(MAX_B_ROWS), .B_CAPACITY(B_CAPACITY)) u_back (
    .clk(clk), .rst(rst),
    .cmd(cmd), .cmd_valid(cmd_valid), .cmd_pop(cmd_pop), .ncols(ncols),
    .out_valid(rsp.valid), .out_ready(rsp.ready),
    .out_column(rsp.out_column), .out_value(rsp.out_value),
    .has_entry(rsp.has_entry), .last(rsp.last)
  );

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.has_entry |-> rsp.last && rsp.out_value == 0 && rsp.out_column == 0)
    else $error("empty row word malformed");

  a_entry_nonzero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.has_entry |-> rsp.out_value != 0)
    else $error("zero sum emitted");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.out_column)
      && $stable(rsp.out_value) && $stable(rsp.has_entry) && $stable(rsp.last))
    else $error("result word changed while stalled");

endmodule
